[hdl/wrgs_pkg.sv]
// Shared types and constants for the water ripple grid stepper.
`default_nettype none

package wrgs_pkg;

  localparam int MODE_W   = 2;
  localparam int COORD_W  = 6;
  localparam int IO_AMP_W = 16;
  localparam int ATT_W    = 16;
  localparam int KEEP_W   = 17;
  localparam int FRAC_SH  = 17;
  localparam int ROUND_BIAS = 65536;

  localparam logic [KEEP_W-1:0] KEEP_ONE   = 17'h10000;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 17'(65536 - 2048);

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_STEP  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef struct packed {
    logic valid;
    logic write;
  } upd_ctl_t;

endpackage

`default_nettype wire

[hdl/wrgs_if.sv]
// Request and response channel interfaces of the water ripple grid stepper.
`default_nettype none

interface wrgs_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [wrgs_pkg::MODE_W-1:0]          mode;
  logic [wrgs_pkg::COORD_W-1:0]         cell_x;
  logic [wrgs_pkg::COORD_W-1:0]         cell_y;
  logic signed [wrgs_pkg::IO_AMP_W-1:0] write_value;

  modport source (output valid, mode, cell_x, cell_y, write_value, input ready);
  modport sink   (input valid, mode, cell_x, cell_y, write_value, output ready);
endinterface

interface wrgs_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [wrgs_pkg::IO_AMP_W-1:0] read_value;
  logic                                 step_saturated;

  modport source (output valid, read_value, step_saturated, input ready);
  modport sink   (input valid, read_value, step_saturated, output ready);
endinterface

`default_nettype wire

[hdl/wrgs_ram.sv]
// Single-port-write, single-port-read grid bank with registered read data.
`default_nettype none

module wrgs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

[hdl/wrgs_update.sv]
// Per-cell update pipeline: difference, damping multiply, round and saturate.
`default_nettype none

module wrgs_update #(
  parameter int AMP_WIDTH = 16,
  parameter int ADDR_W    = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [wrgs_pkg::KEEP_W-1:0]    keep_i,
  input  wrgs_pkg::upd_ctl_t             in_ctl_i,
  input  logic [ADDR_W-1:0]              in_addr_i,
  input  logic signed [AMP_WIDTH+1:0]    sum_i,
  input  logic signed [AMP_WIDTH-1:0]    prev_i,
  output wrgs_pkg::upd_ctl_t             out_ctl_o,
  output logic [ADDR_W-1:0]              out_addr_o,
  output logic signed [AMP_WIDTH-1:0]    out_value_o,
  output logic                           out_sat_o,
  output logic                           busy_o
);

  localparam int DW = AMP_WIDTH + 3;
  localparam int PW = DW + wrgs_pkg::KEEP_W + 1;
  localparam int RW = PW + 1;
  localparam int VW = RW - wrgs_pkg::FRAC_SH;
  localparam logic signed [VW-1:0] VMax = VW'((64'sd1 <<< (AMP_WIDTH - 1)) - 64'sd1);
  localparam logic signed [VW-1:0] VMin = VW'(-(64'sd1 <<< (AMP_WIDTH - 1)));
  localparam logic signed [RW-1:0] RBias = RW'(wrgs_pkg::ROUND_BIAS);

  wrgs_pkg::upd_ctl_t u1_ctl_q, u2_ctl_q;
  logic [ADDR_W-1:0]        u1_addr_q, u2_addr_q;
  logic signed [DW-1:0]     d_q;
  logic signed [PW-1:0]     prod_q;
  logic signed [wrgs_pkg::KEEP_W:0] keep_s;
  logic signed [RW-1:0]     rnd;
  logic signed [VW-1:0]     v;

  assign keep_s = $signed({1'b0, keep_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u1_ctl_q <= '0;
      u2_ctl_q <= '0;
    end else begin
      u1_ctl_q <= in_ctl_i;
      u2_ctl_q <= u1_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    u1_addr_q <= in_addr_i;
    d_q       <= DW'(sum_i) - (DW'(prev_i) <<< 1);
    u2_addr_q <= u1_addr_q;
    prod_q    <= d_q * keep_s;
  end

  // floor((d*keep + 2^16) / 2^17)
  assign rnd = RW'(prod_q) + RBias;
  assign v   = $signed(rnd[RW-1:wrgs_pkg::FRAC_SH]);

  always_comb begin
    out_sat_o = 1'b0;
    if (v > VMax) begin
      out_value_o = VMax[AMP_WIDTH-1:0];
      out_sat_o   = 1'b1;
    end else if (v < VMin) begin
      out_value_o = VMin[AMP_WIDTH-1:0];
      out_sat_o   = 1'b1;
    end else begin
      out_value_o = v[AMP_WIDTH-1:0];
    end
  end

  assign out_ctl_o  = u2_ctl_q;
  assign out_addr_o = u2_addr_q;
  assign busy_o     = u1_ctl_q.valid | u2_ctl_q.valid;

endmodule

`default_nettype wire

[hdl/water_ripple_grid_step.sv]
// Top level of the water ripple grid stepper: two grid banks, sequencer, result register.
//
//   channel   dir  handshake        transaction
//   req_i     in   valid/ready      mode, cell_x, cell_y, write_value
//   rsp_o     out  valid/ready      read_value, step_saturated
//   cfg       in   cfg_we_i         cfg_wdata_i -> attenuation_factor
//
// A step streams the current bank once, one cell per cycle, through an
// 2N-entry line window; the previous bank is read and rewritten in place.
// After reset a zeroing sweep of all N*N cells runs with req_i.ready low.
// A finished result sits in the output register; the next request is taken
// while it waits, and the sequencer stalls only to load a new result.
`default_nettype none

module water_ripple_grid_step #(
  parameter int GRID_SIZE = 64,
  parameter int AMP_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  wrgs_req_if.sink                     req_i,
  wrgs_rsp_if.source                   rsp_o,
  input  logic                         cfg_we_i,
  input  logic [wrgs_pkg::ATT_W-1:0]   cfg_wdata_i
);

  localparam int Cells = GRID_SIZE * GRID_SIZE;
  localparam int AddrW = $clog2(Cells);
  localparam int CntW  = $clog2(Cells + GRID_SIZE + 1);
  localparam int XyW   = $clog2(GRID_SIZE);
  localparam int SumW  = AMP_WIDTH + 2;
  localparam int IoW   = wrgs_pkg::IO_AMP_W;
  localparam int WrW   = (AMP_WIDTH > IoW) ? AMP_WIDTH : IoW;

  localparam logic signed [WrW-1:0] AmpMaxW = WrW'((64'sd1 <<< (AMP_WIDTH - 1)) - 64'sd1);
  localparam logic signed [WrW-1:0] AmpMinW = WrW'(-(64'sd1 <<< (AMP_WIDTH - 1)));
  localparam logic signed [WrW-1:0] IoMaxW  = WrW'((64'sd1 <<< (IoW - 1)) - 64'sd1);
  localparam logic signed [WrW-1:0] IoMinW  = WrW'(-(64'sd1 <<< (IoW - 1)));

  localparam logic [CntW-1:0] CntCells     = CntW'(Cells);
  localparam logic [CntW-1:0] CntCellsLast = CntW'(Cells - 1);
  localparam logic [CntW-1:0] CntStepLast  = CntW'(Cells + GRID_SIZE - 1);
  localparam logic [CntW-1:0] CntGrid      = CntW'(GRID_SIZE);
  localparam logic [XyW-1:0]  XyLast       = XyW'(GRID_SIZE - 1);

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_READ,
    ST_STEP,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e                       state_q;
  logic [CntW-1:0]              cnt_q;
  logic                         cur_q;
  logic [wrgs_pkg::KEEP_W-1:0]  keep_q;
  logic                         sweep_item_q;
  logic                         out_valid_q;
  logic signed [IoW-1:0]        out_rd_q;
  logic                         out_sat_q;
  logic signed [IoW-1:0]        pend_rd_q;
  logic                         pend_sat_q;
  logic                         sat_acc_q;
  logic                         rd_inside_q;
  logic [XyW-1:0]               ctr_x_q, ctr_y_q;
  logic [AddrW-1:0]             ctr_a_q;
  logic                         s1_vld_q, shift_q;
  logic [XyW-1:0]               s1_x_q, s1_y_q;
  logic [AddrW-1:0]             s1_a_q;

  logic signed [AMP_WIDTH-1:0]  win_q [2*GRID_SIZE];

  logic                         req_fire;
  wrgs_pkg::mode_e              req_mode;
  logic                         in_grid;
  logic [AddrW-1:0]             cell_addr;
  logic signed [WrW-1:0]        wv_ext, rd_ext;
  logic signed [AMP_WIDTH-1:0]  wv_sat;
  logic signed [IoW-1:0]        rd_sat;
  logic                         issue_cur, issue_ctr;

  logic [AMP_WIDTH-1:0]         a_rdata, b_rdata;
  logic signed [AMP_WIDTH-1:0]  cur_rdata, prv_rdata;

  logic                         clr_we;
  logic                         cur_we, cur_re, prv_we, prv_re;
  logic [AddrW-1:0]             cur_raddr;
  logic                         a_we, a_re, b_we, b_re;
  logic [AddrW-1:0]             a_waddr, a_raddr, b_waddr, b_raddr;
  logic [AMP_WIDTH-1:0]         a_wdata, b_wdata;

  logic signed [AMP_WIDTH-1:0]  nb_l, nb_r, nb_u, nb_dn;
  logic signed [SumW-1:0]       nb_sum;
  logic                         corner;

  wrgs_pkg::upd_ctl_t           upd_in_ctl, upd_out_ctl;
  logic [AddrW-1:0]             upd_addr;
  logic signed [AMP_WIDTH-1:0]  upd_value;
  logic                         upd_sat, upd_busy;

  assign req_fire  = req_i.valid && req_i.ready;
  assign req_mode  = wrgs_pkg::mode_e'(req_i.mode);
  assign in_grid   = (int'(req_i.cell_x) < GRID_SIZE) && (int'(req_i.cell_y) < GRID_SIZE);
  assign cell_addr = AddrW'(int'(req_i.cell_y) * GRID_SIZE + int'(req_i.cell_x));
  assign issue_cur = cnt_q < CntCells;
  assign issue_ctr = cnt_q >= CntGrid;

  assign wv_ext = WrW'(req_i.write_value);
  always_comb begin
    if (wv_ext > AmpMaxW) begin
      wv_sat = AmpMaxW[AMP_WIDTH-1:0];
    end else if (wv_ext < AmpMinW) begin
      wv_sat = AmpMinW[AMP_WIDTH-1:0];
    end else begin
      wv_sat = wv_ext[AMP_WIDTH-1:0];
    end
  end

  assign cur_rdata = $signed(cur_q ? b_rdata : a_rdata);
  assign prv_rdata = $signed(cur_q ? a_rdata : b_rdata);

  assign rd_ext = WrW'(cur_rdata);
  always_comb begin
    if (rd_ext > IoMaxW) begin
      rd_sat = IoMaxW[IoW-1:0];
    end else if (rd_ext < IoMinW) begin
      rd_sat = IoMinW[IoW-1:0];
    end else begin
      rd_sat = rd_ext[IoW-1:0];
    end
  end

  // bank port roles
  always_comb begin
    clr_we    = 1'b0;
    cur_we    = 1'b0;
    cur_re    = 1'b0;
    prv_re    = 1'b0;
    cur_raddr = cell_addr;
    unique case (state_q)
      ST_SWEEP: begin
        clr_we = 1'b1;
      end
      ST_IDLE: begin
        if (req_fire && in_grid) begin
          unique case (req_mode)
            wrgs_pkg::MODE_WRITE: cur_we = 1'b1;
            wrgs_pkg::MODE_READ:  cur_re = 1'b1;
            wrgs_pkg::MODE_STEP,
            wrgs_pkg::MODE_CLEAR: ;
            default: ;
          endcase
        end
      end
      ST_STEP: begin
        cur_re    = issue_cur;
        cur_raddr = cnt_q[AddrW-1:0];
        prv_re    = issue_ctr;
      end
      default: ;
    endcase
  end

  assign prv_we = upd_out_ctl.valid && upd_out_ctl.write;

  always_comb begin
    a_we    = clr_we | (cur_q ? prv_we : cur_we);
    b_we    = clr_we | (cur_q ? cur_we : prv_we);
    a_waddr = clr_we ? cnt_q[AddrW-1:0] : (cur_q ? upd_addr : cell_addr);
    b_waddr = clr_we ? cnt_q[AddrW-1:0] : (cur_q ? cell_addr : upd_addr);
    a_wdata = clr_we ? '0 : (cur_q ? upd_value : wv_sat);
    b_wdata = clr_we ? '0 : (cur_q ? wv_sat : upd_value);
    a_re    = cur_q ? prv_re : cur_re;
    b_re    = cur_q ? cur_re : prv_re;
    a_raddr = cur_q ? ctr_a_q : cur_raddr;
    b_raddr = cur_q ? cur_raddr : ctr_a_q;
  end

  wrgs_ram #(
    .WIDTH (AMP_WIDTH),
    .DEPTH (Cells)
  ) u_bank_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .re_i    (a_re),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  wrgs_ram #(
    .WIDTH (AMP_WIDTH),
    .DEPTH (Cells)
  ) u_bank_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .re_i    (b_re),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // line window: shift register of the cells streamed from cur_rdata, newest in win_q[0]
  always_ff @(posedge clk_i) begin
    if (shift_q) begin
      win_q[0] <= cur_rdata;
      for (int k = 1; k < 2 * GRID_SIZE; k++) begin
        win_q[k] <= win_q[k-1];
      end
    end
  end

  assign nb_l  = (s1_x_q != '0)    ? win_q[GRID_SIZE]       : '0;
  assign nb_r  = (s1_x_q != XyLast) ? win_q[GRID_SIZE-2]     : '0;
  assign nb_u  = (s1_y_q != '0)    ? win_q[2*GRID_SIZE-1]   : '0;
  assign nb_dn = (s1_y_q != XyLast) ? cur_rdata              : '0;
  assign nb_sum = SumW'(nb_l) + SumW'(nb_r) + SumW'(nb_u) + SumW'(nb_dn);
  assign corner = ((s1_x_q == '0) || (s1_x_q == XyLast)) &&
                  ((s1_y_q == '0) || (s1_y_q == XyLast));

  assign upd_in_ctl.valid = s1_vld_q;
  assign upd_in_ctl.write = !corner;

  wrgs_update #(
    .AMP_WIDTH (AMP_WIDTH),
    .ADDR_W    (AddrW)
  ) u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .keep_i      (keep_q),
    .in_ctl_i    (upd_in_ctl),
    .in_addr_i   (s1_a_q),
    .sum_i       (nb_sum),
    .prev_i      (prv_rdata),
    .out_ctl_o   (upd_out_ctl),
    .out_addr_o  (upd_addr),
    .out_value_o (upd_value),
    .out_sat_o   (upd_sat),
    .busy_o      (upd_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      cnt_q        <= '0;
      cur_q        <= 1'b0;
      keep_q       <= wrgs_pkg::KEEP_RESET;
      sweep_item_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_rd_q     <= '0;
      out_sat_q    <= 1'b0;
      pend_rd_q    <= '0;
      pend_sat_q   <= 1'b0;
      sat_acc_q    <= 1'b0;
      rd_inside_q  <= 1'b0;
      ctr_x_q      <= '0;
      ctr_y_q      <= '0;
      ctr_a_q      <= '0;
      s1_vld_q     <= 1'b0;
      shift_q      <= 1'b0;
      s1_x_q       <= '0;
      s1_y_q       <= '0;
      s1_a_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        keep_q <= wrgs_pkg::KEEP_ONE - wrgs_pkg::KEEP_W'(cfg_wdata_i);
      end
      if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      s1_vld_q <= 1'b0;
      shift_q  <= 1'b0;
      if (prv_we && upd_sat) begin
        sat_acc_q <= 1'b1;
      end
      unique case (state_q)
        ST_SWEEP: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntCellsLast) begin
            cnt_q      <= '0;
            pend_rd_q  <= '0;
            pend_sat_q <= 1'b0;
            state_q    <= sweep_item_q ? ST_FINISH : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_i.valid) begin
            pend_rd_q  <= '0;
            pend_sat_q <= 1'b0;
            cnt_q      <= '0;
            unique case (req_mode)
              wrgs_pkg::MODE_WRITE: begin
                state_q <= ST_FINISH;
              end
              wrgs_pkg::MODE_READ: begin
                rd_inside_q <= in_grid;
                state_q     <= ST_READ;
              end
              wrgs_pkg::MODE_STEP: begin
                ctr_x_q   <= '0;
                ctr_y_q   <= '0;
                ctr_a_q   <= '0;
                sat_acc_q <= 1'b0;
                state_q   <= ST_STEP;
              end
              wrgs_pkg::MODE_CLEAR: begin
                sweep_item_q <= 1'b1;
                state_q      <= ST_SWEEP;
              end
              default: ;
            endcase
          end
        end
        ST_READ: begin
          pend_rd_q <= rd_inside_q ? rd_sat : '0;
          state_q   <= ST_FINISH;
        end
        ST_STEP: begin
          cnt_q   <= cnt_q + 1'b1;
          shift_q <= 1'b1;
          if (issue_ctr) begin
            s1_vld_q <= 1'b1;
            s1_x_q   <= ctr_x_q;
            s1_y_q   <= ctr_y_q;
            s1_a_q   <= ctr_a_q;
            ctr_a_q  <= ctr_a_q + 1'b1;
            if (ctr_x_q == XyLast) begin
              ctr_x_q <= '0;
              ctr_y_q <= ctr_y_q + 1'b1;
            end else begin
              ctr_x_q <= ctr_x_q + 1'b1;
            end
          end
          if (cnt_q == CntStepLast) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!s1_vld_q && !upd_busy) begin
            cur_q      <= !cur_q;
            pend_sat_q <= sat_acc_q;
            state_q    <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q  <= 1'b1;
            out_rd_q     <= pend_rd_q;
            out_sat_q    <= pend_sat_q;
            sweep_item_q <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready          = (state_q == ST_IDLE);
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.read_value     = out_rd_q;
  assign rsp_o.step_saturated = out_sat_q;

endmodule

`default_nettype wire

[hdl/wrgs_checker.sv]
// Port-level checks for the water ripple grid stepper, bound to the top level.
`default_nettype none

module wrgs_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 req_valid_i,
  input logic                                 req_ready_i,
  input logic                                 rsp_valid_i,
  input logic                                 rsp_ready_i,
  input logic signed [wrgs_pkg::IO_AMP_W-1:0] rsp_read_value_i,
  input logic                                 rsp_step_saturated_i
);

  // one transaction at a time: ready drops right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request accepted back to back");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> rsp_valid_i)
    else $error("response dropped before it was taken");

  // only a read carries a value, only a step carries the saturation flag
  a_rsp_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(rsp_step_saturated_i && (rsp_read_value_i != '0)))
    else $error("response carries both read value and saturation flag");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> (!req_ready_i && !rsp_valid_i))
    else $error("handshake active during reset");

endmodule

bind water_ripple_grid_step wrgs_checker u_wrgs_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .req_valid_i          (req_i.valid),
  .req_ready_i          (req_i.ready),
  .rsp_valid_i          (rsp_o.valid),
  .rsp_ready_i          (rsp_o.ready),
  .rsp_read_value_i     (rsp_o.read_value),
  .rsp_step_saturated_i (rsp_o.step_saturated)
);

`default_nettype wire
